// File: hw/rtl/peak_to_peak_led_bar_meter_defines.svh
// Assertion macros shared by the meter RTL.
`ifndef PEAK_TO_PEAK_LED_BAR_METER_DEFINES_SVH
`define PEAK_TO_PEAK_LED_BAR_METER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define P2PM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define P2PM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/p2pm_pkg.sv
package p2pm_pkg;

	localparam int PIXEL_COUNT = 30;

	localparam int SMP_W   = 10;
	localparam int TICK_W  = 16;
	localparam int PIX_W   = 6;
	localparam int LVL_W   = 7;
	localparam int COL_W   = 8;
	localparam int PROD_W  = SMP_W + LVL_W;
	localparam int DCNT_W  = $clog2(PROD_W);
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [SMP_W-1:0]  SAMPLE_INVALID = SMP_W'(1023);
	localparam logic [COL_W-1:0]  FULL           = COL_W'(255);
	localparam logic [COL_W-1:0]  ORANGE_GREEN   = COL_W'(150);

	localparam logic [TICK_W-1:0] WINDOW_RESET = TICK_W'(40);
	localparam logic [SMP_W-1:0]  LOW_RESET    = SMP_W'(3);
	localparam logic [SMP_W-1:0]  HIGH_RESET   = SMP_W'(15);

	localparam logic [LVL_W-1:0]  LVL_FULL   = LVL_W'(PIXEL_COUNT);
	localparam logic [PROD_W-1:0] PC_PROD    = PROD_W'(PIXEL_COUNT);
	localparam logic [LVL_W-1:0]  GREEN_END  = LVL_W'(PIXEL_COUNT / 3);
	localparam logic [LVL_W-1:0]  ORANGE_END = LVL_W'((PIXEL_COUNT * 2) / 3);
	localparam logic [PIX_W-1:0]  PIX_LAST   = PIX_W'(PIXEL_COUNT - 1);

	localparam logic [1:0] REG_WINDOW_MS  = 2'd0;
	localparam logic [1:0] REG_LEVEL_LOW  = 2'd1;
	localparam logic [1:0] REG_LEVEL_HIGH = 2'd2;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

endpackage

// File: hw/rtl/peak_to_peak_led_bar_meter.sv
// Channel   Handshake                 Payload
// req       req_valid / req_ready     req_type, sample_value
// pix       pix_valid / pix_ready     pixel_index, red, green, blue, peak_amplitude,
//                                     bar_level, last
// cfg       APB write, pready high    paddr, pwdata (prdata on read)
//
// A sample item, or a tick that does not close the window, leaves the block idle.
// A tick that closes the window captures the amplitude, sets up the level in ST_PREP, runs
// the bit-serial divider in ST_DIV unless the level is already known, then emits 30 pixel
// items, one per cycle while pix_ready stays high; req_ready is low throughout.
// A low pix_ready holds the current pixel item in place until it is taken.
// Reset is asynchronous and restores the register defaults and an empty window.
`include "peak_to_peak_led_bar_meter_defines.svh"

module peak_to_peak_led_bar_meter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           req_type,
	input  logic [p2pm_pkg::SMP_W-1:0]     sample_value,
	output logic                           pix_valid,
	input  logic                           pix_ready,
	output logic [p2pm_pkg::PIX_W-1:0]     pixel_index,
	output logic [p2pm_pkg::COL_W-1:0]     red,
	output logic [p2pm_pkg::COL_W-1:0]     green,
	output logic [p2pm_pkg::COL_W-1:0]     blue,
	output logic [p2pm_pkg::SMP_W-1:0]     peak_amplitude,
	output logic [p2pm_pkg::LVL_W-1:0]     bar_level,
	output logic                           last,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [p2pm_pkg::ADDR_W-1:0]    paddr,
	input  logic [p2pm_pkg::DATA_W-1:0]    pwdata,
	output logic [p2pm_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                        state_q;
	logic [p2pm_pkg::TICK_W-1:0]       window_q;
	logic [p2pm_pkg::SMP_W-1:0]        low_q;
	logic [p2pm_pkg::SMP_W-1:0]        high_q;
	logic [p2pm_pkg::SMP_W-1:0]        max_q;
	logic [p2pm_pkg::SMP_W-1:0]        min_q;
	logic                              seen_q;
	logic [p2pm_pkg::TICK_W-1:0]       tick_q;
	logic [p2pm_pkg::SMP_W-1:0]        amp_q;
	logic [p2pm_pkg::LVL_W-1:0]        lvl_q;
	logic [p2pm_pkg::PROD_W-1:0]       quo_q;
	logic [p2pm_pkg::SMP_W-1:0]        rem_q;
	logic [p2pm_pkg::SMP_W-1:0]        den_q;
	logic [p2pm_pkg::DCNT_W-1:0]       cnt_q;
	logic [p2pm_pkg::PIX_W-1:0]        pix_q;

	logic                              req_acc;
	logic                              cfg_wr;
	logic [1:0]                        reg_idx;
	logic [p2pm_pkg::TICK_W-1:0]       tick_inc;
	logic [p2pm_pkg::SMP_W-1:0]        amp_new;
	logic [p2pm_pkg::SMP_W-1:0]        diff;
	logic [p2pm_pkg::PROD_W-1:0]       prod;
	logic [p2pm_pkg::SMP_W:0]          rem_sh;
	logic [p2pm_pkg::SMP_W:0]          rem_sub;
	logic                              qbit;
	logic [p2pm_pkg::PROD_W-1:0]       quo_next;
	logic [p2pm_pkg::LVL_W-1:0]        pix_ext;
	logic                              lit;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[3:2];
	assign tick_inc  = tick_q + p2pm_pkg::TICK_W'(1);
	assign amp_new   = (seen_q && (max_q >= min_q)) ? (max_q - min_q) : '0;
	assign diff      = amp_q - low_q;
	assign prod      = p2pm_pkg::PROD_W'(diff) * p2pm_pkg::PC_PROD;
	assign rem_sh    = {rem_q, quo_q[p2pm_pkg::PROD_W-1]};
	assign rem_sub   = rem_sh - {1'b0, den_q};
	assign qbit      = (rem_sh >= {1'b0, den_q});
	assign quo_next  = {quo_q[p2pm_pkg::PROD_W-2:0], qbit};

	always_comb begin
		case (reg_idx)
			p2pm_pkg::REG_WINDOW_MS:  prdata = p2pm_pkg::DATA_W'(window_q);
			p2pm_pkg::REG_LEVEL_LOW:  prdata = p2pm_pkg::DATA_W'(low_q);
			p2pm_pkg::REG_LEVEL_HIGH: prdata = p2pm_pkg::DATA_W'(high_q);
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= p2pm_pkg::WINDOW_RESET;
			low_q    <= p2pm_pkg::LOW_RESET;
			high_q   <= p2pm_pkg::HIGH_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				p2pm_pkg::REG_WINDOW_MS:  window_q <= pwdata[p2pm_pkg::TICK_W-1:0];
				p2pm_pkg::REG_LEVEL_LOW:  low_q    <= pwdata[p2pm_pkg::SMP_W-1:0];
				p2pm_pkg::REG_LEVEL_HIGH: high_q   <= pwdata[p2pm_pkg::SMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q   <= '0;
			min_q   <= p2pm_pkg::SAMPLE_INVALID;
			seen_q  <= 1'b0;
			tick_q  <= '0;
			pix_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc && (req_type == p2pm_pkg::REQ_SAMPLE)) begin
						if (sample_value != p2pm_pkg::SAMPLE_INVALID) begin
							if (sample_value > max_q) begin
								max_q <= sample_value;
							end
							if (sample_value < min_q) begin
								min_q <= sample_value;
							end
							seen_q <= 1'b1;
						end
					end else if (req_acc) begin
						if (tick_inc < window_q) begin
							tick_q <= tick_inc;
						end else begin
							max_q   <= '0;
							min_q   <= p2pm_pkg::SAMPLE_INVALID;
							seen_q  <= 1'b0;
							tick_q  <= '0;
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					pix_q <= '0;
					cnt_q <= p2pm_pkg::DCNT_W'(p2pm_pkg::PROD_W - 1);
					if ((high_q <= low_q) || (amp_q <= low_q)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - p2pm_pkg::DCNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (pix_ready) begin
						if (pix_q == p2pm_pkg::PIX_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							pix_q <= pix_q + p2pm_pkg::PIX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the closing window and the divider.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				amp_q <= amp_new;
			end
			ST_PREP: begin
				quo_q <= prod;
				rem_q <= '0;
				den_q <= high_q - low_q;
				if (high_q <= low_q) begin
					lvl_q <= (amp_q >= high_q) ? p2pm_pkg::LVL_FULL : '0;
				end else begin
					lvl_q <= '0;
				end
			end
			ST_DIV: begin
				quo_q <= quo_next;
				rem_q <= qbit ? rem_sub[p2pm_pkg::SMP_W-1:0] : rem_sh[p2pm_pkg::SMP_W-1:0];
				if (cnt_q == '0) begin
					lvl_q <= (quo_next > p2pm_pkg::PC_PROD) ? p2pm_pkg::LVL_FULL
						: quo_next[p2pm_pkg::LVL_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign pix_ext = p2pm_pkg::LVL_W'(pix_q);
	assign lit     = (pix_ext < lvl_q);

	always_comb begin
		red   = '0;
		green = '0;
		if (lit) begin
			if (pix_ext < p2pm_pkg::GREEN_END) begin
				green = p2pm_pkg::FULL;
			end else if (pix_ext < p2pm_pkg::ORANGE_END) begin
				red   = p2pm_pkg::FULL;
				green = p2pm_pkg::ORANGE_GREEN;
			end else begin
				red = p2pm_pkg::FULL;
			end
		end
	end

	assign pix_valid      = (state_q == ST_EMIT);
	assign pixel_index    = pix_q;
	assign blue           = '0;
	assign peak_amplitude = amp_q;
	assign bar_level      = lvl_q;
	assign last           = (pix_q == p2pm_pkg::PIX_LAST);

	`P2PM_ASSERT_NOW(a_no_overlap, pix_valid, !req_ready, "input taken while pixels pending")
	`P2PM_ASSERT_NOW(a_level_range, pix_valid, bar_level <= p2pm_pkg::LVL_FULL, "level above pixel count")
	`P2PM_ASSERT_NEXT(a_last_frees, pix_valid && pix_ready && last, req_ready, "not idle after last pixel")
	`P2PM_ASSERT_NEXT(a_sample_quiet, req_valid && req_ready && !req_type, !pix_valid, "sample caused a pixel")
	`P2PM_ASSERT_NEXT(a_step_pixel, pix_valid && pix_ready && !last, pix_valid && pixel_index == $past(pixel_index) + 1'b1, "pixel index did not step")

endmodule

// File: tb/p2pm_frame_checker.sv
`timescale 1ns / 1ps

module p2pm_frame_checker
	import p2pm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  logic              req_type,
	input  logic [SMP_W-1:0]  sample_value,
	input  logic              pix_valid,
	input  logic              pix_ready,
	input  logic [PIX_W-1:0]  pixel_index,
	input  logic [COL_W-1:0]  red,
	input  logic [COL_W-1:0]  green,
	input  logic [COL_W-1:0]  blue,
	input  logic [SMP_W-1:0]  peak_amplitude,
	input  logic [LVL_W-1:0]  bar_level,
	input  logic              last,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	output int                mismatches,
	output int                pixels_owed
);

	typedef struct {
		logic [PIX_W-1:0] index;
		logic [COL_W-1:0] r;
		logic [COL_W-1:0] g;
		logic [COL_W-1:0] b;
		logic [SMP_W-1:0] amplitude;
		logic [LVL_W-1:0] level;
		logic             is_last;
	} pixel_t;

	pixel_t expected_pixels[$];

	logic [TICK_W-1:0] window_len;
	logic [TICK_W-1:0] ticks_seen;
	logic [SMP_W-1:0]  thresh_low;
	logic [SMP_W-1:0]  thresh_high;
	logic [SMP_W-1:0]  sample_max;
	logic [SMP_W-1:0]  sample_min;
	logic              sample_seen;

	function automatic logic [LVL_W-1:0] bar_for(input logic [SMP_W-1:0] amp);
		int lvl;
		if (thresh_high <= thresh_low)
			return (amp >= thresh_high) ? LVL_W'(PIXEL_COUNT) : '0;
		if (amp <= thresh_low)
			return '0;
		lvl = ((int'(amp) - int'(thresh_low)) * PIXEL_COUNT) /
			(int'(thresh_high) - int'(thresh_low));
		if (lvl > PIXEL_COUNT)
			lvl = PIXEL_COUNT;
		return LVL_W'(lvl);
	endfunction

	task automatic clear_window();
		sample_max  = '0;
		sample_min  = SAMPLE_INVALID;
		sample_seen = 1'b0;
		ticks_seen  = '0;
	endtask

	task automatic close_window();
		logic [SMP_W-1:0] amp;
		logic [LVL_W-1:0] lvl;
		pixel_t px;
		amp = (sample_seen && sample_max >= sample_min) ? sample_max - sample_min : '0;
		lvl = bar_for(amp);
		for (int i = 0; i < PIXEL_COUNT; i++) begin
			px.index     = PIX_W'(i);
			px.r         = '0;
			px.g         = '0;
			px.b         = '0;
			px.amplitude = amp;
			px.level     = lvl;
			px.is_last   = (i == PIXEL_COUNT - 1);
			if (i < lvl) begin
				if (i < PIXEL_COUNT / 3) begin
					px.g = FULL;
				end else if (i < (PIXEL_COUNT * 2) / 3) begin
					px.r = FULL;
					px.g = ORANGE_GREEN;
				end else begin
					px.r = FULL;
				end
			end
			expected_pixels.push_back(px);
		end
		clear_window();
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t px;
		if (!arst_n) begin
			window_len  = WINDOW_RESET;
			thresh_low  = LOW_RESET;
			thresh_high = HIGH_RESET;
			clear_window();
			expected_pixels.delete();
			mismatches  = 0;
			pixels_owed = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WINDOW_MS:  window_len  = pwdata[TICK_W-1:0];
					REG_LEVEL_LOW:  thresh_low  = pwdata[SMP_W-1:0];
					REG_LEVEL_HIGH: thresh_high = pwdata[SMP_W-1:0];
					default: ;
				endcase
			end
			if (pix_valid && pix_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel item %0d arrived with none expected", pixel_index);
					mismatches++;
				end else begin
					px = expected_pixels.pop_front();
					check_field("pixel_index", px.index, pixel_index);
					check_field("red", px.r, red);
					check_field("green", px.g, green);
					check_field("blue", px.b, blue);
					check_field("peak_amplitude", px.amplitude, peak_amplitude);
					check_field("bar_level", px.level, bar_level);
					check_field("last", px.is_last, last);
				end
			end
			if (req_valid && req_ready) begin
				if (req_type == REQ_SAMPLE) begin
					if (sample_value != SAMPLE_INVALID) begin
						if (sample_value > sample_max)
							sample_max = sample_value;
						if (sample_value < sample_min)
							sample_min = sample_value;
						sample_seen = 1'b1;
					end
				end else begin
					ticks_seen = ticks_seen + 1'b1;
					if (ticks_seen >= window_len)
						close_window();
				end
			end
			pixels_owed = expected_pixels.size();
		end
	end

endmodule

// File: tb/tb_peak_to_peak_led_bar_meter.sv
`timescale 1ns / 1ps

module tb_peak_to_peak_led_bar_meter;
	import p2pm_pkg::*;

	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         HOLD_OFF    = 600;
	localparam int         SETTLE      = 25;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              req_valid    = 1'b0;
	logic              req_type     = 1'b0;
	logic [SMP_W-1:0]  sample_value = '0;
	logic              pix_ready    = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;

	logic              req_ready;
	logic              pix_valid;
	logic [PIX_W-1:0]  pixel_index;
	logic [COL_W-1:0]  red;
	logic [COL_W-1:0]  green;
	logic [COL_W-1:0]  blue;
	logic [SMP_W-1:0]  peak_amplitude;
	logic [LVL_W-1:0]  bar_level;
	logic              last;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int mismatches;
	int pixels_owed;
	int send_idle_pct = 33;
	int recv_idle_pct = 78;
	int cycle_count   = 0;
	int hold_off_left = 0;
	logic hold_off_go   = 1'b0;
	logic hold_off_done = 1'b0;

	peak_to_peak_led_bar_meter dut (.*);

	p2pm_frame_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// The long hold-off lets the block fill up and push back on the item channel.
	always @(posedge clk) begin
		if (hold_off_left != 0) begin
			pix_ready     <= 1'b0;
			hold_off_left <= hold_off_left - 1;
		end else if (hold_off_go && !hold_off_done) begin
			pix_ready     <= 1'b0;
			hold_off_left <= HOLD_OFF;
			hold_off_done <= 1'b1;
		end else begin
			pix_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input logic kind, input logic [SMP_W-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= kind;
		sample_value <= value;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pixels_owed != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] index, input logic [DATA_W-1:0] value,
			input int width);
		logic [DATA_W-1:0] junk;
		junk    = $urandom() << width;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= junk | value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic cfg_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_settings(input int win, input int lo, input int hi);
		cfg_write(REG_WINDOW_MS, DATA_W'(win), TICK_W);
		cfg_write(REG_LEVEL_LOW, DATA_W'(lo), SMP_W);
		if ($urandom_range(3) == 0)
			cfg_write(REG_UNUSED, $urandom(), 0);
		cfg_write(REG_LEVEL_HIGH, DATA_W'(hi), SMP_W);
		cfg_release();
	endtask

	task automatic random_settings();
		int win;
		int lo;
		int hi;
		win = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
		case ($urandom_range(5))
			0: begin
				lo = $urandom_range(100);
				hi = lo + $urandom_range(60, 1);
			end
			1: begin
				lo = $urandom_range(500);
				hi = $urandom_range(1022, lo + 1);
			end
			2: begin
				hi = $urandom_range(1022);
				lo = $urandom_range(1022, hi);
			end
			3: begin
				lo = 0;
				hi = 1022;
			end
			4: begin
				lo = $urandom_range(1023, 1022);
				hi = 1023;
			end
			default: begin
				lo = 0;
				hi = $urandom_range(5, 1);
			end
		endcase
		apply_settings(win, lo, hi);
	endtask

	task automatic run_random(input int count);
		int base;
		int spread;
		int v;
		base   = $urandom_range(1022);
		spread = 20;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(3) == 0) begin
				send_item(REQ_TICK, SMP_W'($urandom()));
				base = $urandom_range(1022);
				case ($urandom_range(3))
					0: spread = 3;
					1: spread = 20;
					2: spread = 150;
					default: spread = 1022;
				endcase
			end else begin
				case ($urandom_range(9))
					0: v = SAMPLE_INVALID;
					1: v = 0;
					2: v = 1022;
					default: v = base + $urandom_range(spread);
				endcase
				if (v > SAMPLE_INVALID)
					v = 1022;
				send_item(REQ_SAMPLE, SMP_W'(v));
			end
		end
	endtask

	task automatic random_phase();
		for (int s = 0; s < 4; s++) begin
			settle();
			random_settings();
			run_random(21);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Threshold registers keep their reset values here.
		cfg_write(REG_WINDOW_MS, 2, TICK_W);
		cfg_release();
		send_item(REQ_SAMPLE, 0);
		send_item(REQ_SAMPLE, SAMPLE_INVALID);
		send_item(REQ_SAMPLE, 1022);
		send_item(REQ_TICK, 0);
		send_item(REQ_TICK, SMP_W'(1023));
		send_item(REQ_SAMPLE, 5);
		send_item(REQ_TICK, 0);
		send_item(REQ_TICK, 0);
		send_item(REQ_TICK, 0);
		send_item(REQ_TICK, 0);

		settle();
		apply_settings(1, 10, 10);
		send_item(REQ_SAMPLE, 100);
		send_item(REQ_SAMPLE, 110);
		send_item(REQ_TICK, 0);
		send_item(REQ_SAMPLE, 100);
		send_item(REQ_SAMPLE, 109);
		send_item(REQ_TICK, 0);

		settle();
		cfg_write(REG_UNUSED, 32'hffff_ffff, 0);
		apply_settings(0, 1023, 0);
		send_item(REQ_TICK, 0);

		// A long window is shortened while it is open.
		settle();
		apply_settings(65535, 0, 1023);
		send_item(REQ_SAMPLE, 0);
		send_item(REQ_SAMPLE, 500);
		send_item(REQ_TICK, 0);
		send_item(REQ_TICK, 0);
		settle();
		cfg_write(REG_WINDOW_MS, 2, TICK_W);
		cfg_release();
		send_item(REQ_TICK, 0);

		random_phase();

		send_idle_pct = 78;
		recv_idle_pct = 33;
		random_phase();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		settle();
		apply_settings(1, 3, 15);
		hold_off_go <= 1'b1;
		for (int k = 0; k < 10; k++) begin
			send_item(REQ_SAMPLE, SMP_W'($urandom()));
			send_item(REQ_TICK, 0);
		end
		random_phase();

		settle();
		if (mismatches == 0 && pixels_owed == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/p2pm_pkg.sv
hw/rtl/peak_to_peak_led_bar_meter.sv
tb/p2pm_frame_checker.sv
tb/tb_peak_to_peak_led_bar_meter.sv
